/* hw/rtl/avcc_pkg.sv */
// Shared types and constants for the AVCC to Annex B converter.
// Used by every module of the block; depends on nothing.
package avcc_pkg;

    localparam int unsigned REG_LENGTH_SIZE = 0;
    localparam int unsigned ADDR_W          = 3;
    localparam int unsigned LS_W            = 3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_SIZE = 2'd1;
    localparam logic [1:0] ERR_ZERO_LEN = 2'd2;
    localparam logic [1:0] ERR_TRUNC    = 2'd3;

    localparam logic [LS_W-1:0] LS_RESET = 3'd2;

    localparam logic [4:0] NAL_IDR = 5'd5;
    localparam logic [4:0] NAL_SPS = 5'd7;
    localparam logic [4:0] NAL_PPS = 5'd8;

    // Annex B start code 00 00 00 01
    localparam logic [2:0] SC_LEN      = 3'd4;
    localparam logic [7:0] SC_ZERO     = 8'h00;
    localparam logic [7:0] SC_LAST     = 8'h01;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // one classified input byte, handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       sc;       // start code goes before data
        logic       emit;     // data is a payload byte
        logic       mark;     // params-here on the start code
        logic       last;     // sample ends with this command
        logic       has_idr;
        logic [1:0] err;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

/* hw/rtl/avcc_front.sv */
// Front end: accepts sample bytes, parses length prefixes, classifies NAL units.
// Depends on avcc_pkg.
module avcc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [avcc_pkg::LS_W-1:0]   length_size,
    input  logic                        fire,
    input  logic [7:0]                  data_byte,
    input  logic                        sample_end,
    output logic                        push,
    output avcc_pkg::cmd_t              cmd
);
    import avcc_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_FIRST,
        PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  prb_reg, prb_next;
    logic [31:0] left_reg, left_next;
    logic        pss_reg, pss_next;
    logic        mdone_reg, mdone_next;
    logic        idr_reg, idr_next;
    logic [1:0]  err_reg, err_next;

    logic        ls_ok;
    logic [2:0]  prb_inc;
    logic [31:0] left_shift;
    logic [31:0] left_dec;
    logic [4:0]  nal_type;

    always_comb
    begin
        phase_next = phase_reg;
        prb_next   = prb_reg;
        left_next  = left_reg;
        pss_next   = pss_reg;
        mdone_next = mdone_reg;
        idr_next   = idr_reg;
        err_next   = err_reg;

        cmd         = '0;
        cmd.data    = data_byte;

        ls_ok      = (length_size == 3'd1) || (length_size == 3'd2) || (length_size == 3'd4);
        prb_inc    = prb_reg + 3'd1;
        left_shift = {left_reg[23:0], data_byte};
        left_dec   = left_reg - 32'd1;
        nal_type   = data_byte[4:0];

        if (err_reg == ERR_NONE)
        begin
            if (!ls_ok)
            begin
                err_next = ERR_BAD_SIZE;
            end
            else if (phase_reg == PH_LEN)
            begin
                left_next = left_shift;
                prb_next  = prb_inc;
                if (prb_inc >= length_size)
                begin
                    prb_next = 3'd0;
                    if (left_shift == 32'd0)
                        err_next = ERR_ZERO_LEN;
                    else
                        phase_next = PH_FIRST;
                end
            end
            else
            begin
                if (phase_reg == PH_FIRST)
                begin
                    cmd.sc = 1'b1;
                    if (nal_type == NAL_SPS || nal_type == NAL_PPS)
                    begin
                        pss_next = 1'b1;
                    end
                    else if (nal_type == NAL_IDR)
                    begin
                        if (!pss_reg && !mdone_reg)
                        begin
                            cmd.mark   = 1'b1;
                            mdone_next = 1'b1;
                        end
                        idr_next = 1'b1;
                    end
                end
                cmd.emit   = 1'b1;
                left_next  = left_dec;
                phase_next = (left_dec == 32'd0) ? PH_LEN : PH_BODY;
            end
        end

        if (sample_end)
        begin
            cmd.last    = 1'b1;
            cmd.has_idr = idr_next;
            if (err_next == ERR_NONE && (phase_next != PH_LEN || prb_next != 3'd0))
                cmd.err = ERR_TRUNC;
            else
                cmd.err = err_next;
            // sample done: back to the start-of-sample state
            phase_next = PH_LEN;
            prb_next   = 3'd0;
            left_next  = 32'd0;
            pss_next   = 1'b0;
            mdone_next = 1'b0;
            idr_next   = 1'b0;
            err_next   = ERR_NONE;
        end

        push = fire && (cmd.emit || sample_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            prb_reg   <= 3'd0;
            left_reg  <= 32'd0;
            pss_reg   <= 1'b0;
            mdone_reg <= 1'b0;
            idr_reg   <= 1'b0;
            err_reg   <= ERR_NONE;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            prb_reg   <= prb_next;
            left_reg  <= left_next;
            pss_reg   <= pss_next;
            mdone_reg <= mdone_next;
            idr_reg   <= idr_next;
            err_reg   <= err_next;
        end
    end

endmodule

/* hw/rtl/avcc_queue.sv */
// Short command queue between front and back end.
// Depends on avcc_pkg.
module avcc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  avcc_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output avcc_pkg::cmd_t  head,
    output avcc_pkg::qstat_t stat
);
    import avcc_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    always_comb
    begin
        stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
        stat.empty = (cnt_reg == '0);
        do_push    = push && !stat.full;
        do_pop     = pop && !stat.empty;
        head       = mem_reg[rd_ptr_reg];

        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* hw/rtl/avcc_back.sv */
// Back end: expands each command into start-code, payload or status transactions.
// Depends on avcc_pkg.
module avcc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  avcc_pkg::cmd_t  head,
    input  logic            head_valid,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);
    import avcc_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic        vld_reg, vld_next;
    logic [15:0] data_reg, data_next;
    logic [1:0]  user_reg, user_next;
    logic        last_reg, last_next;

    logic        slot_free;
    logic        item_last;
    logic        in_sc;
    logic [7:0]  byte_sel;

    always_comb
    begin
        slot_free = !vld_reg || m_tready;
        in_sc     = head.sc && (idx_reg < SC_LEN);
        item_last = !in_sc;

        if (in_sc)
            byte_sel = (idx_reg == SC_LEN - 3'd1) ? SC_LAST : SC_ZERO;
        else if (head.emit)
            byte_sel = head.data;
        else
            byte_sel = 8'h00;

        pop       = head_valid && slot_free && item_last;
        idx_next  = idx_reg;
        vld_next  = vld_reg;
        data_next = data_reg;
        user_next = user_reg;
        last_next = last_reg;

        if (slot_free)
        begin
            vld_next = head_valid;
            if (head_valid)
            begin
                idx_next  = item_last ? 3'd0 : idx_reg + 3'd1;
                data_next = {5'd0,
                             item_last ? head.err : ERR_NONE,
                             item_last && head.last && head.has_idr,
                             byte_sel};
                user_next = {in_sc && (idx_reg == 3'd0) && head.mark, head.emit};
                last_next = item_last && head.last;
                if (!(item_last && head.last))
                    data_next[10:9] = ERR_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 3'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

/* hw/rtl/avcc_to_annexb_converter_unit.sv */
// Top level of the AVCC (length-prefixed) to Annex B converter.
// Input commands pass through the command queue, then the output register.
// Throughput: one input byte per cycle; start codes add four output bytes per unit.
// The four-entry command queue and the output register set the stall behavior.
// Reset (rst_n, async, active low): parser state, queue and output cleared;
// length_size returns to 2. Depends on avcc_pkg, avcc_front, avcc_queue, avcc_back.
module avcc_to_annexb_converter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // sample_end
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [7:0] out_byte, [8] has_idr,
                                                     // [10:9] error_code, [15:11] zero
    output logic [1:0]                    m_tuser,   // [0] byte_valid, [1] params_here
    output logic                          m_tlast,   // packet_end
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [avcc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import avcc_pkg::*;

    logic [LS_W-1:0] ls_reg;
    logic            wr_en;
    logic            fire;
    logic            push;
    logic            pop;
    cmd_t            cmd;
    cmd_t            head;
    qstat_t          qstat;

    // Register file: only length_size, at word index 0
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite &&
                    (paddr[ADDR_W-1:2] == REG_LENGTH_SIZE[ADDR_W-3:0]);
    assign prdata = (paddr[ADDR_W-1:2] == REG_LENGTH_SIZE[ADDR_W-3:0]) ?
                    {29'd0, ls_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ls_reg <= LS_RESET;
        else if (wr_en)
            ls_reg <= pwdata[LS_W-1:0];
    end

    // Input accepted whenever the queue has room
    assign s_tready = !qstat.full;
    assign fire     = s_tvalid && s_tready;

    avcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .length_size (ls_reg),
        .fire        (fire),
        .data_byte   (s_tdata),
        .sample_end  (s_tlast),
        .push        (push),
        .cmd         (cmd)
    );

    avcc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .head     (head),
        .stat     (qstat)
    );

    avcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!qstat.empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // params-here only rides on a leading zero start-code byte
    a_mark_on_sc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[7:0] == 8'h00 && m_tuser[0])
        else $error("params_here on a non start-code transaction");

    // status fields stay clear except on the packet end
    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[10:8] == 3'd0)
        else $error("status fields set before packet end");

    // status-only transactions occur only at packet end
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'h00)
        else $error("status-only transaction not at packet end");

    // queue never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("command queue overflow");

endmodule
